/* hw/rtl/sam_pkg.sv */
// ----------------------------------------------------------------------------
// sam_pkg
// Shared types and constants of the sprite affine matrix setup block.
// ----------------------------------------------------------------------------
package sam_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int TRIG_BITS    = 30;
    localparam int XW           = 34;
    localparam int IN_W         = 336;
    localparam int OUT_W        = 192;

    localparam logic [31:0] INV_GAIN = 32'd652032874;

    localparam logic [31:0] ATAN [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] scx;
        logic signed [31:0] scy;
        logic signed [31:0] skx;
        logic signed [31:0] sky;
        logic [30:0]        w;
        logic [30:0]        h;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
    } pay_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [31:0]        axm;
        logic [31:0]        aym;
        logic               axn;
        logic               ayn;
    } carry_t;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

/* hw/rtl/sprite_affine_matrix_setup.sv */
// ----------------------------------------------------------------------------
// sprite_affine_matrix_setup
// Builds a sprite's 2D affine matrix and translation from its transform.
// ----------------------------------------------------------------------------
// Input stream s_*: one transfer carries one sprite transform. Output stream
// m_*: one transfer carries the four linear terms, the translation and a
// saturation flag. Every input transfer gives exactly one output transfer,
// in order.
// Pipeline: an input capture register, then one register stage per CORDIC
// step (CORDIC_STEPS capped at 24), then the multiply, round and saturate
// stages, with the output buffer behind them.
// Throughput: one transfer per cycle unless the pipeline holds; every stage
// otherwise takes a new item each cycle, all multipliers fully pipelined.
// Reset clears all valid bits, the output buffer's included; no data is reset.
// When the receiver stalls, a two-entry output buffer absorbs one more
// result; once it is full the whole pipeline holds and s_tready drops,
// so no item is lost or repeated.
// ----------------------------------------------------------------------------
module sprite_affine_matrix_setup #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // rotation_turns[15:0], pos_x, pos_y, scale_x, scale_y, skew_x, skew_y,
    // width[30:0], height[30:0], anchor_x, anchor_y, zero pad
    input  logic [sam_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m00, m10, m01, m11, tx, ty
    output logic [sam_pkg::OUT_W-1:0]     m_tdata,
    // saturated
    output logic [0:0]                    m_tuser
);

    localparam int NSTEP = (CORDIC_STEPS > sam_pkg::ATAN_ENTRIES) ?
                           sam_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int NV    = NSTEP + 13;
    localparam int XW    = sam_pkg::XW;
    localparam int W2    = 66 - FRAC_BITS;
    localparam int HW    = W2 - 32;
    localparam int S3    = W2 + 32;
    localparam int M3W   = S3 - FRAC_BITS;
    localparam int TW    = 64 - FRAC_BITS;
    localparam int SW    = TW + 3;
    localparam int CN    = 10;

    logic adv;
    logic push;
    logic pop;
    logic [NV-1:0] v_reg;

    // cordic pipeline
    logic signed [XW-1:0]  x_reg    [0:NSTEP];
    logic signed [XW-1:0]  y_reg    [0:NSTEP];
    logic signed [XW-1:0]  z_reg    [0:NSTEP];
    sam_pkg::quad_t        quad_reg [0:NSTEP];
    sam_pkg::pay_t         pay_reg  [0:NSTEP];

    // quadrant stage
    logic signed [XW-1:0]  qc_reg;
    logic signed [XW-1:0]  qs_reg;
    logic [31:0]           qkxm_reg, qkym_reg, qcxm_reg, qcym_reg;
    logic                  qkxn_reg, qkyn_reg, qcxn_reg, qcyn_reg;
    logic [30:0]           qw_reg, qh_reg;
    sam_pkg::carry_t       qcr_reg;

    sam_pkg::carry_t       cr_reg [0:CN-1];

    logic [31:0]           bt_reg [4];
    logic [31:0]           bk_reg [4];
    logic [31:0]           bc_reg [4];
    logic [30:0]           bz_reg [4];
    logic                  bn_reg [4];

    logic [63:0]           m1p_reg [4];
    logic [31:0]           m1c_reg [4];
    logic [30:0]           m1z_reg [4];
    logic                  m1n_reg [4];

    logic [33:0]           r1m_reg [4];
    logic [31:0]           r1c_reg [4];
    logic [30:0]           r1z_reg [4];
    logic                  r1n_reg [4];

    logic [65:0]           m2p_reg [4];
    logic [30:0]           m2z_reg [4];
    logic                  m2n_reg [4];

    logic [W2-1:0]         r2m_reg [4];
    logic [30:0]           r2z_reg [4];
    logic                  r2n_reg [4];

    logic [62:0]           plo_reg [4];
    logic [HW+30:0]        phi_reg [4];
    logic                  an_reg  [4];

    logic [S3-1:0]         s3_reg  [4];
    logic                  s3n_reg [4];

    logic [31:0]           mv_next [4];
    logic [31:0]           mm_next [4];
    logic                  mf_next [4];
    logic [31:0]           mv_reg  [4];
    logic [31:0]           mm_reg  [4];
    logic                  mn_reg  [4];
    logic                  mf_reg  [4];

    logic [63:0]           tp_reg  [4];
    logic                  tn_reg  [4];
    logic [31:0]           t1v_reg [4];
    logic                  t1f_reg;

    logic [TW-1:0]         tr_reg  [4];
    logic                  t2n_reg [4];
    logic [31:0]           t2v_reg [4];
    logic                  t2f_reg;

    logic signed [SW-1:0]  tx_reg, ty_reg;
    logic [31:0]           t3v_reg [4];
    logic                  t3f_reg;

    logic [31:0]           tx_sat, ty_sat;
    logic                  tx_f, ty_f;
    logic [sam_pkg::OUT_W:0] res;

    logic                    out_valid_reg, out_valid_next;
    logic                    sp_valid_reg, sp_valid_next;
    logic [sam_pkg::OUT_W:0] out_data_reg, sp_data_reg;

    assign adv      = !sp_valid_reg;
    assign s_tready = adv;
    assign push     = adv && v_reg[NV-1];
    assign pop      = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NV-2:0], s_tvalid};
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0]    <= XW'(sam_pkg::INV_GAIN);
            y_reg[0]    <= '0;
            z_reg[0]    <= XW'({s_tdata[13:0], 16'b0});
            quad_reg[0] <= sam_pkg::quad_t'(s_tdata[15:14]);
            pay_reg[0].px  <= s_tdata[47:16];
            pay_reg[0].py  <= s_tdata[79:48];
            pay_reg[0].scx <= s_tdata[111:80];
            pay_reg[0].scy <= s_tdata[143:112];
            pay_reg[0].skx <= s_tdata[175:144];
            pay_reg[0].sky <= s_tdata[207:176];
            pay_reg[0].w   <= s_tdata[238:208];
            pay_reg[0].h   <= s_tdata[269:239];
            pay_reg[0].ax  <= s_tdata[301:270];
            pay_reg[0].ay  <= s_tdata[333:302];
        end
    end

    for (genvar gi = 0; gi < NSTEP; gi++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!z_reg[gi][XW-1]) begin
                    x_reg[gi+1] <= x_reg[gi] - (y_reg[gi] >>> gi);
                    y_reg[gi+1] <= y_reg[gi] + (x_reg[gi] >>> gi);
                    z_reg[gi+1] <= z_reg[gi] - $signed(XW'(sam_pkg::ATAN[gi]));
                end else begin
                    x_reg[gi+1] <= x_reg[gi] + (y_reg[gi] >>> gi);
                    y_reg[gi+1] <= y_reg[gi] - (x_reg[gi] >>> gi);
                    z_reg[gi+1] <= z_reg[gi] + $signed(XW'(sam_pkg::ATAN[gi]));
                end
                quad_reg[gi+1] <= quad_reg[gi];
                pay_reg[gi+1]  <= pay_reg[gi];
            end
        end
    end

    // quadrant and factor magnitudes
    always_ff @(posedge aclk) begin
        if (adv) begin
            case (quad_reg[NSTEP])
                sam_pkg::QUAD_0: begin
                    qc_reg <= x_reg[NSTEP];
                    qs_reg <= y_reg[NSTEP];
                end
                sam_pkg::QUAD_90: begin
                    qc_reg <= -y_reg[NSTEP];
                    qs_reg <= x_reg[NSTEP];
                end
                sam_pkg::QUAD_180: begin
                    qc_reg <= -x_reg[NSTEP];
                    qs_reg <= -y_reg[NSTEP];
                end
                default: begin
                    qc_reg <= y_reg[NSTEP];
                    qs_reg <= -x_reg[NSTEP];
                end
            endcase
            qkxm_reg <= sam_pkg::abs32(pay_reg[NSTEP].skx);
            qkym_reg <= sam_pkg::abs32(pay_reg[NSTEP].sky);
            qcxm_reg <= sam_pkg::abs32(pay_reg[NSTEP].scx);
            qcym_reg <= sam_pkg::abs32(pay_reg[NSTEP].scy);
            qkxn_reg <= pay_reg[NSTEP].skx[31];
            qkyn_reg <= pay_reg[NSTEP].sky[31];
            qcxn_reg <= pay_reg[NSTEP].scx[31];
            qcyn_reg <= pay_reg[NSTEP].scy[31];
            qw_reg   <= pay_reg[NSTEP].w;
            qh_reg   <= pay_reg[NSTEP].h;
            qcr_reg.px  <= pay_reg[NSTEP].px;
            qcr_reg.py  <= pay_reg[NSTEP].py;
            qcr_reg.axm <= sam_pkg::abs32(pay_reg[NSTEP].ax);
            qcr_reg.aym <= sam_pkg::abs32(pay_reg[NSTEP].ay);
            qcr_reg.axn <= pay_reg[NSTEP].ax[31];
            qcr_reg.ayn <= pay_reg[NSTEP].ay[31];
        end
    end

    // term set-up: trig magnitude and sign of each of the four products
    always_ff @(posedge aclk) begin
        if (adv) begin
            bt_reg[0] <= 32'(qc_reg[XW-1] ? -qc_reg : qc_reg);
            bt_reg[1] <= 32'(qs_reg[XW-1] ? -qs_reg : qs_reg);
            bt_reg[2] <= 32'(qs_reg[XW-1] ? -qs_reg : qs_reg);
            bt_reg[3] <= 32'(qc_reg[XW-1] ? -qc_reg : qc_reg);
            bk_reg[0] <= qkxm_reg;
            bk_reg[1] <= qkym_reg;
            bk_reg[2] <= qkxm_reg;
            bk_reg[3] <= qkym_reg;
            bc_reg[0] <= qcxm_reg;
            bc_reg[1] <= qcxm_reg;
            bc_reg[2] <= qcym_reg;
            bc_reg[3] <= qcym_reg;
            bz_reg[0] <= qw_reg;
            bz_reg[1] <= qw_reg;
            bz_reg[2] <= qh_reg;
            bz_reg[3] <= qh_reg;
            bn_reg[0] <= qc_reg[XW-1] ^ qkxn_reg ^ qcxn_reg;
            bn_reg[1] <= qs_reg[XW-1] ^ qkyn_reg ^ qcxn_reg;
            bn_reg[2] <= !qs_reg[XW-1] ^ qkxn_reg ^ qcyn_reg;
            bn_reg[3] <= qc_reg[XW-1] ^ qkyn_reg ^ qcyn_reg;
            cr_reg[0] <= qcr_reg;
            for (int k = 1; k < CN; k++) begin
                cr_reg[k] <= cr_reg[k-1];
            end
        end
    end

    // product chain on magnitudes
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                m1p_reg[k] <= bt_reg[k] * bk_reg[k];
                m1c_reg[k] <= bc_reg[k];
                m1z_reg[k] <= bz_reg[k];
                m1n_reg[k] <= bn_reg[k];

                r1m_reg[k] <= 34'((m1p_reg[k] + (64'd1 << (sam_pkg::TRIG_BITS - 1)))
                                  >> sam_pkg::TRIG_BITS);
                r1c_reg[k] <= m1c_reg[k];
                r1z_reg[k] <= m1z_reg[k];
                r1n_reg[k] <= m1n_reg[k];

                m2p_reg[k] <= 66'(r1m_reg[k]) * 66'(r1c_reg[k]);
                m2z_reg[k] <= r1z_reg[k];
                m2n_reg[k] <= r1n_reg[k];

                r2m_reg[k] <= W2'((m2p_reg[k] + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
                r2z_reg[k] <= m2z_reg[k];
                r2n_reg[k] <= m2n_reg[k];

                plo_reg[k] <= 63'(r2m_reg[k][31:0]) * 63'(r2z_reg[k]);
                phi_reg[k] <= (HW+31)'(r2m_reg[k][W2-1:32]) * (HW+31)'(r2z_reg[k]);
                an_reg[k]  <= r2n_reg[k];

                s3_reg[k]  <= S3'({phi_reg[k], 32'b0}) + S3'(plo_reg[k])
                              + (S3'(1) << (FRAC_BITS - 1));
                s3n_reg[k] <= an_reg[k];
            end
        end
    end

    // final shift and clamp of the linear terms
    always_comb begin
        logic [M3W-1:0] mag;
        logic           sat;
        for (int k = 0; k < 4; k++) begin
            mag = s3_reg[k][S3-1:FRAC_BITS];
            if (s3n_reg[k]) begin
                sat = (|mag[M3W-1:32]) || (mag[31] && (|mag[30:0]));
                mm_next[k] = sat ? 32'h8000_0000 : mag[31:0];
                mv_next[k] = sat ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
            end else begin
                sat = |mag[M3W-1:31];
                mm_next[k] = sat ? 32'h7FFF_FFFF : mag[31:0];
                mv_next[k] = mm_next[k];
            end
            mf_next[k] = sat;
        end
    end

    // linear term registers and translation
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                mv_reg[k] <= mv_next[k];
                mm_reg[k] <= mm_next[k];
                mn_reg[k] <= s3n_reg[k];
                mf_reg[k] <= mf_next[k];
            end

            tp_reg[0] <= 64'(mm_reg[0]) * 64'(cr_reg[7].axm);
            tp_reg[1] <= 64'(mm_reg[2]) * 64'(cr_reg[7].aym);
            tp_reg[2] <= 64'(mm_reg[1]) * 64'(cr_reg[7].axm);
            tp_reg[3] <= 64'(mm_reg[3]) * 64'(cr_reg[7].aym);
            tn_reg[0] <= mn_reg[0] ^ cr_reg[7].axn;
            tn_reg[1] <= mn_reg[2] ^ cr_reg[7].ayn;
            tn_reg[2] <= mn_reg[1] ^ cr_reg[7].axn;
            tn_reg[3] <= mn_reg[3] ^ cr_reg[7].ayn;
            t1f_reg   <= mf_reg[0] | mf_reg[1] | mf_reg[2] | mf_reg[3];

            for (int k = 0; k < 4; k++) begin
                t1v_reg[k] <= mv_reg[k];
                tr_reg[k]  <= TW'((tp_reg[k] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
                t2n_reg[k] <= tn_reg[k];
                t2v_reg[k] <= t1v_reg[k];
                t3v_reg[k] <= t2v_reg[k];
            end
            t2f_reg <= t1f_reg;
            t3f_reg <= t2f_reg;

            tx_reg <= SW'(cr_reg[9].px)
                      + (t2n_reg[0] ? $signed(SW'(tr_reg[0])) : -$signed(SW'(tr_reg[0])))
                      + (t2n_reg[1] ? $signed(SW'(tr_reg[1])) : -$signed(SW'(tr_reg[1])));
            ty_reg <= SW'(cr_reg[9].py)
                      + (t2n_reg[2] ? $signed(SW'(tr_reg[2])) : -$signed(SW'(tr_reg[2])))
                      + (t2n_reg[3] ? $signed(SW'(tr_reg[3])) : -$signed(SW'(tr_reg[3])));
        end
    end

    always_comb begin
        tx_f   = !((&tx_reg[SW-1:31]) || !(|tx_reg[SW-1:31]));
        ty_f   = !((&ty_reg[SW-1:31]) || !(|ty_reg[SW-1:31]));
        tx_sat = tx_f ? (tx_reg[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : tx_reg[31:0];
        ty_sat = ty_f ? (ty_reg[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : ty_reg[31:0];
        res    = {t3f_reg | tx_f | ty_f, ty_sat, tx_sat,
                  t3v_reg[3], t3v_reg[2], t3v_reg[1], t3v_reg[0]};
    end

    // output buffer, two entries
    always_comb begin
        out_valid_next = out_valid_reg;
        sp_valid_next  = sp_valid_reg;
        if (push) begin
            out_valid_next = 1'b1;
            if (out_valid_reg && !pop) begin
                sp_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = sp_valid_reg;
            sp_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sp_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            sp_valid_reg  <= sp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && (!out_valid_reg || pop)) begin
            out_data_reg <= res;
        end else if (push) begin
            sp_data_reg <= res;
        end else if (pop && sp_valid_reg) begin
            out_data_reg <= sp_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg[sam_pkg::OUT_W-1:0];
    assign m_tuser  = out_data_reg[sam_pkg::OUT_W];

endmodule
